// File: hdl/tlcm_pkg.sv
package tlcm_pkg;

  localparam int unsigned TickW = 16;

  localparam logic [TickW-1:0] NormalPeriodRst = 16'd400;
  localparam logic [TickW-1:0] BlinkPeriodRst  = 16'd200;
  localparam logic [TickW-1:0] LongPressRst    = 16'd400;
  localparam logic [TickW-1:0] DoubleGapRst    = 16'd20;

  // lamp register bit positions
  localparam int unsigned LampRed    = 0;
  localparam int unsigned LampYellow = 1;
  localparam int unsigned LampGreen  = 2;

  typedef enum logic [1:0] {
    CFG_NORMAL_PERIOD = 2'd0,
    CFG_BLINK_PERIOD  = 2'd1,
    CFG_LONG_PRESS    = 2'd2,
    CFG_DOUBLE_GAP    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_EMERG  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_REDYEL = 2'd1,
    PH_GREEN  = 2'd2,
    PH_YELLOW = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CK_IDLE   = 3'd0,
    CK_PRESS1 = 3'd1,
    CK_GAP    = 3'd2,
    CK_PRESS2 = 3'd3,
    CK_HELD   = 3'd4
  } click_state_t;

  typedef enum logic [1:0] {
    G_NONE   = 2'd0,
    G_SINGLE = 2'd1,
    G_DOUBLE = 2'd2,
    G_LONG   = 2'd3
  } gesture_t;

  typedef struct packed {
    logic       red;
    logic       yellow;
    logic       green;
    logic [1:0] mode;
  } lamp_view_t;

endpackage

// File: hdl/traffic_light_with_click_modes.sv
// channel | direction | handshake            | payload
// in_     | request   | in_valid / in_ready  | in_button_pressed (one 5 ms tick)
// out_    | result    | out_valid / out_ready| lamps, light_mode, gesture
// cfg_    | write     | cfg_wr_en            | cfg_index, cfg_data
// One request per cycle while the result register is not stalled.
// Input register, then one pass of lamp and click logic into the result register.
// Reset (rst_n low, synchronous) empties both registers and restores the
// power-up periods and timers. A stalled result register holds the request
// waiting behind it; nothing is lost or repeated.
module traffic_light_with_click_modes (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_button_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_red_on,
  output logic        out_yellow_on,
  output logic        out_green_on,
  output logic [1:0]  out_light_mode,
  output logic [1:0]  out_gesture,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tlcm_pkg::*;

  logic [TickW-1:0] normal_period_r, blink_period_r, long_press_r, double_gap_r;
  logic             in_valid_r, button_r;
  logic             out_valid_r;
  logic             out_free, adv;
  gesture_t         gesture;
  lamp_view_t       view;
  lamp_view_t       view_r;
  gesture_t         gesture_r;

  assign out_free = !out_valid_r || out_ready;
  assign adv      = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_period_r <= NormalPeriodRst;
      blink_period_r  <= BlinkPeriodRst;
      long_press_r    <= LongPressRst;
      double_gap_r    <= DoubleGapRst;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NORMAL_PERIOD: normal_period_r <= cfg_data;
        CFG_BLINK_PERIOD:  blink_period_r  <= cfg_data;
        CFG_LONG_PRESS:    long_press_r    <= cfg_data;
        CFG_DOUBLE_GAP:    double_gap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) button_r <= in_button_pressed;
  end

  tlcm_click u_click (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .pressed          (button_r),
    .long_press_ticks (long_press_r),
    .double_gap_ticks (double_gap_r),
    .gesture          (gesture)
  );

  tlcm_lamp u_lamp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .normal_period_ticks (normal_period_r),
    .blink_period_ticks  (blink_period_r),
    .gesture             (gesture),
    .view                (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      view_r    <= view;
      gesture_r <= gesture;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_on     = view_r.red;
  assign out_yellow_on  = view_r.yellow;
  assign out_green_on   = view_r.green;
  assign out_light_mode = view_r.mode;
  assign out_gesture    = gesture_r;

`ifndef ASSERT_OFF
  a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("processed request did not reach result register");
  a_single_blink: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && gesture_r == G_SINGLE) |-> view_r.mode == MODE_BLINK)
    else $error("single click without blink mode");
  a_double_emerg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && gesture_r == G_DOUBLE) |-> view_r.mode == MODE_EMERG)
    else $error("double click without emergency mode");
  a_long_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && gesture_r == G_LONG) |-> view_r.mode == MODE_NORMAL)
    else $error("long press without normal mode");
`endif

endmodule

// File: hdl/tlcm_click.sv
module tlcm_click (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      pressed,
  input  logic [tlcm_pkg::TickW-1:0] long_press_ticks,
  input  logic [tlcm_pkg::TickW-1:0] double_gap_ticks,
  output tlcm_pkg::gesture_t        gesture
);
  import tlcm_pkg::*;

  click_state_t      state_r, state_nxt;
  logic [TickW-1:0]  count_r, count_nxt;
  logic [TickW-1:0]  count_dec;
  logic              expired;

  assign count_dec = count_r - 1'b1;
  assign expired   = (count_dec == '0);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    gesture   = G_NONE;
    case (state_r)
      CK_IDLE: begin
        if (pressed) begin
          state_nxt = CK_PRESS1;
          count_nxt = long_press_ticks;
        end
      end
      CK_PRESS1: begin
        count_nxt = count_dec;
        if (expired) begin
          state_nxt = CK_HELD;
          gesture   = G_LONG;
        end else if (!pressed) begin
          state_nxt = CK_GAP;
          count_nxt = double_gap_ticks;
        end
      end
      CK_GAP: begin
        count_nxt = count_dec;
        if (expired) begin
          state_nxt = CK_IDLE;
          gesture   = G_SINGLE;
        end else if (pressed) begin
          state_nxt = CK_PRESS2;
          count_nxt = long_press_ticks;
        end
      end
      CK_PRESS2: begin
        count_nxt = count_dec;
        if (expired) begin
          state_nxt = CK_HELD;
          gesture   = G_LONG;
        end else if (!pressed) begin
          state_nxt = CK_IDLE;
          gesture   = G_DOUBLE;
        end
      end
      CK_HELD: begin
        if (!pressed) state_nxt = CK_IDLE;
      end
      default: state_nxt = CK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CK_IDLE;
      count_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == CK_IDLE || state_r == CK_HELD) |-> gesture == G_NONE)
    else $error("gesture reported from idle or held state");
`endif

endmodule

// File: hdl/tlcm_lamp.sv
module tlcm_lamp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [tlcm_pkg::TickW-1:0] normal_period_ticks,
  input  logic [tlcm_pkg::TickW-1:0] blink_period_ticks,
  input  tlcm_pkg::gesture_t         gesture,
  output tlcm_pkg::lamp_view_t       view
);
  import tlcm_pkg::*;

  logic [1:0]        mode_r, mode_nxt;
  phase_t            phase_r, phase_nxt;
  logic [2:0]        lamp_r, lamp_nxt;
  logic              short_r, short_nxt;
  logic [TickW-1:0]  period_r, period_nxt;
  logic [TickW-1:0]  period_dec;
  logic              step;

  assign period_dec = period_r - 1'b1;
  assign step       = (period_dec == '0);
  assign period_nxt = step ? (short_r ? blink_period_ticks : normal_period_ticks) : period_dec;

  // lamp step uses the mode held before this tick
  always_comb begin
    phase_nxt = phase_r;
    lamp_nxt  = lamp_r;
    if (step) begin
      case (mode_r)
        MODE_NORMAL: begin
          case (phase_r)
            PH_RED: begin
              lamp_nxt[LampYellow] = 1'b1;
              phase_nxt = PH_REDYEL;
            end
            PH_REDYEL: begin
              lamp_nxt[LampRed]    = 1'b0;
              lamp_nxt[LampYellow] = 1'b0;
              lamp_nxt[LampGreen]  = 1'b1;
              phase_nxt = PH_GREEN;
            end
            PH_GREEN: begin
              lamp_nxt[LampGreen]  = 1'b0;
              lamp_nxt[LampYellow] = 1'b1;
              phase_nxt = PH_YELLOW;
            end
            default: begin
              lamp_nxt[LampYellow] = 1'b0;
              lamp_nxt[LampRed]    = 1'b1;
              phase_nxt = PH_RED;
            end
          endcase
        end
        MODE_BLINK: begin
          lamp_nxt[LampRed]    = 1'b0;
          lamp_nxt[LampGreen]  = 1'b0;
          lamp_nxt[LampYellow] = ~lamp_r[LampYellow];
        end
        MODE_EMERG: begin
          lamp_nxt[LampRed]    = 1'b1;
          lamp_nxt[LampYellow] = 1'b0;
          lamp_nxt[LampGreen]  = 1'b0;
        end
        default: lamp_nxt = lamp_r;
      endcase
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    short_nxt = short_r;
    case (gesture)
      G_SINGLE: begin
        mode_nxt  = MODE_BLINK;
        short_nxt = 1'b1;
      end
      G_DOUBLE: mode_nxt = MODE_EMERG;
      G_LONG: begin
        mode_nxt  = MODE_NORMAL;
        short_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  assign view.red    = lamp_nxt[LampRed];
  assign view.yellow = lamp_nxt[LampYellow];
  assign view.green  = lamp_nxt[LampGreen];
  assign view.mode   = mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      phase_r  <= PH_RED;
      lamp_r   <= 3'b001;
      short_r  <= 1'b0;
      period_r <= NormalPeriodRst;
    end else if (adv) begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      lamp_r   <= lamp_nxt;
      short_r  <= short_nxt;
      period_r <= period_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_emerg_red: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step && mode_r == MODE_EMERG) |=> lamp_r == 3'b001)
    else $error("emergency step left lamps other than red");
`endif

endmodule
